// File: hw/rtl/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lkvc_state_e;

  // sequencer to datapath
  typedef struct packed {
    logic accept;
    logic cmp;
    logic commit;
  } lkvc_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic match;
    logic out_free;
  } lkvc_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkvc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire  [WIDTH-1:0]                     wdata_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_seq.sv
// Sequencer: accepts a request, scans the entries one per cycle, then commits.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_seq #(
  parameter int DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  wire  lkvc_pkg::lkvc_stat_t           stat_i,
  output logic                                 in_ready_o,
  output lkvc_pkg::lkvc_ctrl_t                 ctrl_o,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_o,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] cmp_idx_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lkvc_pkg::lkvc_state_e state_q, state_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          scan_done;
  logic          issue;

  assign scan_done = cmp_vld_q && (stat_i.match || (cmp_idx_q == IW'(DEPTH - 1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (scan_done) state_d = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (stat_i.out_free) state_d = lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctrl_o        = '0;
    issue         = 1'b0;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      lkvc_pkg::ST_SCAN: begin
        ctrl_o.cmp = cmp_vld_q;
        issue      = !scan_done;
      end
      lkvc_pkg::ST_UPDATE: begin
        ctrl_o.commit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    if (ctrl_o.accept) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d  = rd_idx_q + IW'(1);
      cmp_idx_d = rd_idx_q;
      cmp_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lkvc_pkg::ST_IDLE;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= cmp_idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  assign rd_addr_o = rd_idx_q;
  assign cmp_idx_o = cmp_idx_q;

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache of DEPTH entries with least-recently-used
// replacement. Each request is a get or a set and gives exactly one result.
// Keys and values sit in one single-port RAM that is scanned one entry per
// cycle through a single key comparator; the scan stops at the first hit.
// A request that misses scans all DEPTH entries before its update state;
// one that hits entry k stops the scan at entry k. The result is held in an
// output register, so a new request is taken while it waits; a request
// stalls only in its final update cycle until the previous result has gone.
// No clearing pass is needed after reset. The capacity register (reset 16)
// is read as 1 when written 0 and as DEPTH above DEPTH; lowering it below
// the occupancy evicts nothing until later inserts.
module lru_key_value_cache #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 31,
  parameter int VALUE_BITS = 31
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [lkvc_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          cmd_i,
  input  wire  [KEY_BITS-1:0]          lookup_key_i,
  input  wire  [VALUE_BITS-1:0]        store_value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         hit_o,
  output logic [VALUE_BITS-1:0]        read_value_o,
  output logic                         evicted_o
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW   = IW;
  localparam int OW   = $clog2(DEPTH + 1);
  localparam int CmpW = (OW > lkvc_pkg::CFG_W) ? OW : lkvc_pkg::CFG_W;
  localparam int EntW = KEY_BITS + VALUE_BITS;

  lkvc_pkg::lkvc_ctrl_t ctrl;
  lkvc_pkg::lkvc_stat_t stat;

  logic [IW-1:0] rd_addr, cmp_idx;

  logic [lkvc_pkg::CFG_W-1:0] cap_q;
  logic [CmpW-1:0]            cap_ext, cap_eff;
  logic                       full;

  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  found_q, found_d;
  logic                  free_found_q, free_found_d;
  logic [IW-1:0]         slot_q, slot_d, lru_q, lru_d, free_q, free_d;
  logic [VALUE_BITS-1:0] hit_val_q, hit_val_d;

  logic [DEPTH-1:0] valid_q, valid_d;
  logic [RW-1:0]    rank_q [DEPTH];
  logic [RW-1:0]    rank_d [DEPTH];
  logic [OW-1:0]    occ_q, occ_d;

  logic            ram_we;
  logic [IW-1:0]   ram_addr;
  logic [EntW-1:0] ram_rdata;
  logic [IW-1:0]   tgt;
  logic            do_promote, do_insert;
  logic [RW-1:0]   tgt_rank;

  logic                  out_valid_q, out_valid_d;
  logic                  hit_q, hit_d, ev_q, ev_d;
  logic [VALUE_BITS-1:0] rv_q, rv_d;

  lkvc_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .rd_addr_o  (rd_addr),
    .cmp_idx_o  (cmp_idx)
  );

  lkvc_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({val_q, key_q}),
    .rdata_o (ram_rdata)
  );

  // capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(DEPTH)) begin
      cap_eff = CmpW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full = CmpW'(occ_q) >= cap_eff;

  // key compare on the entry read last cycle
  assign stat.match    = ctrl.cmp && valid_q[cmp_idx] && (ram_rdata[KEY_BITS-1:0] == key_q);
  assign stat.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    found_d      = found_q;
    free_found_d = free_found_q;
    slot_d       = slot_q;
    lru_d        = lru_q;
    free_d       = free_q;
    hit_val_d    = hit_val_q;
    if (ctrl.accept) begin
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else if (ctrl.cmp) begin
      if (stat.match) begin
        found_d   = 1'b1;
        slot_d    = cmp_idx;
        hit_val_d = ram_rdata[EntW-1:KEY_BITS];
      end
      if (valid_q[cmp_idx] && (OW'(rank_q[cmp_idx]) + OW'(1) == occ_q)) begin
        lru_d = cmp_idx;
      end
      if (!valid_q[cmp_idx] && !free_found_q) begin
        free_d       = cmp_idx;
        free_found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      cmd_q <= cmd_i;
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
    slot_q    <= slot_d;
    lru_q     <= lru_d;
    free_q    <= free_d;
    hit_val_q <= hit_val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      found_q      <= found_d;
      free_found_q <= free_found_d;
    end
  end

  // commit decision
  always_comb begin
    tgt        = free_q;
    ram_we     = 1'b0;
    do_promote = 1'b0;
    do_insert  = 1'b0;
    hit_d      = 1'b0;
    ev_d       = 1'b0;
    rv_d       = '0;
    if (found_q) begin
      tgt        = slot_q;
      do_promote = 1'b1;
      hit_d      = 1'b1;
      if (cmd_q == lkvc_pkg::CMD_SET) begin
        ram_we = ctrl.commit;
      end else begin
        rv_d = hit_val_q;
      end
    end else if (cmd_q == lkvc_pkg::CMD_SET) begin
      ram_we = ctrl.commit;
      if (full) begin
        tgt        = lru_q;
        do_promote = 1'b1;
        ev_d       = 1'b1;
      end else begin
        do_insert = 1'b1;
      end
    end
  end

  assign ram_addr = ctrl.commit ? tgt : rd_addr;
  assign tgt_rank = rank_q[tgt];

  // recency update, all entries in parallel
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < DEPTH; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (ctrl.commit && do_promote) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_q[i] && (rank_q[i] < tgt_rank)) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end
      rank_d[tgt] = '0;
    end else if (ctrl.commit && do_insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end
      rank_d[tgt]  = '0;
      valid_d[tgt] = 1'b1;
      occ_d        = occ_q + OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      hit_q <= hit_d;
      ev_q  <= ev_d;
      rv_q  <= rv_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rv_q;
  assign evicted_o    = ev_q;

`ifndef SYNTH
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy out of step with valid bits");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= DEPTH)
    else $error("occupancy above depth");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a lookup is in progress");

  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.commit && do_insert) |-> (free_found_q && !valid_q[free_q]))
    else $error("insert without a free entry");
`endif

endmodule

`default_nettype wire
